### rtl/lrusc_pkg.sv
// shared types, constants and codes for the lru set-associative cache tag model
`timescale 1ns / 1ps
package lrusc_pkg;

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_STAMP_BITS   = 32;

  localparam int ADDR_W   = 64;
  localparam int TOTAL_W  = 32;
  localparam int SIB_W    = 3;
  localparam int WAYS_W   = 4;
  localparam int OFS_W    = 5;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [SIB_W-1:0]  SIB_RESET  = 3'd4;
  localparam logic [WAYS_W-1:0] WAYS_RESET = 4'd1;
  localparam logic [OFS_W-1:0]  OFS_RESET  = 5'd4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_SET_INDEX_BITS = 2'd0;
  localparam logic [1:0] REG_WAYS_IN_USE    = 2'd1;
  localparam logic [1:0] REG_OFFSET_BITS    = 2'd2;

  // access kinds
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_STORE  = 2'd1;
  localparam logic [1:0] ACT_MODIFY = 2'd2;
  localparam logic [1:0] ACT_INSTR  = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic               was_hit;
    logic               was_miss;
    logic               was_eviction;
    logic               extra_hit;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] eviction_total;
  } rsp_t;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v,
                                                 input logic en);
    logic [TOTAL_W-1:0] r;
    r = v;
    if (en && v != TOTAL_MAX) r = v + TOTAL_W'(1);
    return r;
  endfunction

endpackage

### rtl/lrusc_front.sv
// front end: drops instruction fetches, splits the address into tag and set
`timescale 1ns / 1ps
module lrusc_front
  import lrusc_pkg::*;
#(
  parameter int SET_W  = 6,
  parameter int SB_W   = 3,
  parameter int ENT_W  = 71
) (
  input  logic             req_valid,
  input  req_t             req,
  input  logic [SB_W-1:0]  set_bits,
  input  logic [OFS_W-1:0] offset_bits,
  output logic             push,
  output logic [ENT_W-1:0] entry
);

  localparam int SH_W = $clog2(ADDR_W);

  logic [SH_W-1:0]   tag_shift;
  logic [ADDR_W-1:0] tag;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  set_idx;
  logic              is_modify;

  always_comb begin
    tag_shift = SH_W'(set_bits) + SH_W'(offset_bits);
    tag       = req.address >> tag_shift;
    set_mask  = SET_W'(((SET_W+1)'(1) << set_bits) - (SET_W+1)'(1));
    set_idx   = SET_W'(req.address >> offset_bits) & set_mask;
    is_modify = (req.action == ACT_MODIFY);
    push      = req_valid && (req.action != ACT_INSTR);
    entry     = {is_modify, set_idx, tag};
  end

endmodule

### rtl/lrusc_queue.sv
// two-entry queue between front and back
`timescale 1ns / 1ps
module lrusc_queue #(
  parameter int ENT_W = 71
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [ENT_W-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [ENT_W-1:0] head
);

  logic [ENT_W-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

### rtl/lrusc_back.sv
// back end: set lookup, lru victim choice, line update and totals
`timescale 1ns / 1ps
module lrusc_back
  import lrusc_pkg::*;
#(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int STAMP_BITS   = DEF_STAMP_BITS,
  parameter int SET_W        = 6,
  parameter int CNT_W        = 4,
  parameter int ENT_W        = 71
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  logic [ENT_W-1:0] q_head,
  output logic             q_pop,
  input  logic [CNT_W-1:0] ways,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp
);

  localparam int ROWS  = 1 << MAX_SET_BITS;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  typedef logic [MAX_WAYS-1:0][ADDR_W-1:0]     tag_row_t;
  typedef logic [MAX_WAYS-1:0][STAMP_BITS-1:0] stamp_row_t;

  state_t state;
  state_t state_next;

  tag_row_t            tag_mem   [ROWS];
  stamp_row_t          stamp_mem [ROWS];
  logic [MAX_WAYS-1:0] valid_mem [ROWS];

  tag_row_t            rd_tags;
  stamp_row_t          rd_stamps;
  logic [MAX_WAYS-1:0] rd_valid;
  logic [ADDR_W-1:0]   cur_tag;
  logic [SET_W-1:0]    cur_set;
  logic                cur_mod;

  // valid rows are cleared one per cycle after reset
  logic                clearing;
  logic [SET_W-1:0]    clr_row;

  logic [STAMP_BITS-1:0] use_clock;
  logic [TOTAL_W-1:0]    hits;
  logic [TOTAL_W-1:0]    misses;
  logic [TOTAL_W-1:0]    evictions;

  logic [MAX_WAYS-1:0] row_valid;
  logic [MAX_WAYS-1:0] in_use;
  logic                hit;
  logic                hit_found;
  logic [WAY_W-1:0]    hit_way;
  logic                free_found;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    lru_way;
  logic [WAY_W-1:0]    sel_way;
  logic                evict;
  tag_row_t            wr_tags;
  stamp_row_t          wr_stamps;
  logic [MAX_WAYS-1:0] wr_valid;
  logic [TOTAL_W-1:0]  hits_mid;
  logic                out_free;

  assign out_free = !rsp_valid || !rsp_stall;
  assign q_pop    = (state == ST_IDLE) && !clearing && !q_empty && out_free;

  // lookup over the registered set row
  always_comb begin
    row_valid  = rd_valid;
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    lru_way    = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (CNT_W'(w) < ways);
      if (in_use[w] && row_valid[w] && rd_tags[w] == cur_tag && !hit_found) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (in_use[w] && !row_valid[w] && !free_found) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && rd_stamps[w] < rd_stamps[lru_way]) lru_way = WAY_W'(w);
    end
    hit     = hit_found;
    evict   = !hit_found && !free_found;
    sel_way = hit_found ? hit_way : (free_found ? free_way : lru_way);
    wr_tags   = rd_tags;
    wr_stamps = rd_stamps;
    wr_valid  = rd_valid;
    wr_tags[sel_way]   = cur_tag;
    wr_stamps[sel_way] = use_clock;
    wr_valid[sel_way]  = 1'b1;
    hits_mid = sat_inc(hits, hit);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_pop) state_next = ST_LOOK;
      ST_LOOK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // row memories: read on pop, write back in the lookup cycle
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_tags   <= tag_mem[q_head[ADDR_W +: SET_W]];
      rd_stamps <= stamp_mem[q_head[ADDR_W +: SET_W]];
      rd_valid  <= valid_mem[q_head[ADDR_W +: SET_W]];
      cur_tag   <= q_head[ADDR_W-1:0];
      cur_set   <= q_head[ADDR_W +: SET_W];
      cur_mod   <= q_head[ENT_W-1];
    end
    if (state == ST_LOOK) begin
      tag_mem[cur_set]   <= wr_tags;
      stamp_mem[cur_set] <= wr_stamps;
    end
    if (clearing) valid_mem[clr_row] <= '0;
    else if (state == ST_LOOK) valid_mem[cur_set] <= wr_valid;
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      rsp.was_hit        <= hit;
      rsp.was_miss       <= !hit;
      rsp.was_eviction   <= evict;
      rsp.extra_hit      <= cur_mod;
      rsp.hit_total      <= sat_inc(hits_mid, cur_mod);
      rsp.miss_total     <= sat_inc(misses, !hit);
      rsp.eviction_total <= sat_inc(evictions, evict);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      use_clock <= '0;
      hits      <= '0;
      misses    <= '0;
      evictions <= '0;
      rsp_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_row   <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_row <= clr_row + SET_W'(1);
        if (clr_row == SET_W'(ROWS - 1)) clearing <= 1'b0;
      end
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (state == ST_LOOK) begin
        use_clock <= use_clock + STAMP_BITS'(1);
        hits      <= sat_inc(hits_mid, cur_mod);
        misses    <= sat_inc(misses, !hit);
        evictions <= sat_inc(evictions, evict);
        rsp_valid <= 1'b1;
      end
    end
  end

endmodule

### rtl/lru_set_assoc_cache_sim.sv
// top level of the lru set-associative cache tag model
// usage:
//   request channel (req_valid, req_stall, req): one trace access per item, an
//   action code and a 64-bit byte address; taken when req_valid is high and
//   req_stall is low. instruction fetches are taken and dropped.
//   response channel (rsp_valid, rsp_stall, rsp): one item per load, store or
//   modify with hit, miss, eviction, extra hit and the saturating totals.
//   apb port: set_index_bits at 0x0, ways_in_use at 0x4, offset_bits at 0x8;
//   write only while no access is in flight.
// the path from request to response runs through the queue, the set row read
//   and the update. the back end handles one access at a time: it reads and then
//   writes back a set row before it pops another access from the queue.
// a two-entry queue sits between front and back, so requests keep flowing
//   while a response waits; when rsp_stall holds, the back end stops after
//   the response register and the queue fills, then req_stall rises.
// reset: use clock and totals zero, registers to their defaults (4 set bits,
//   1 way, 4 offset bits); then a clearing pass over every set row of the
//   storage marks every line invalid. items are queued during the pass but
//   looked up only after it ends.
`timescale 1ns / 1ps
module lru_set_assoc_cache_sim
  import lrusc_pkg::*;
#(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int STAMP_BITS   = DEF_STAMP_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SB_W  = $clog2(MAX_SET_BITS + 1) > 0 ? $clog2(MAX_SET_BITS + 1) : 1;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);
  localparam int ENT_W = 1 + SET_W + ADDR_W;

  // configuration registers
  logic [SIB_W-1:0]  set_index_bits;
  logic [WAYS_W-1:0] ways_in_use;
  logic [OFS_W-1:0]  offset_bits;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= SIB_RESET;
      ways_in_use    <= WAYS_RESET;
      offset_bits    <= OFS_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SET_INDEX_BITS: set_index_bits <= pwdata[SIB_W-1:0];
        REG_WAYS_IN_USE:    ways_in_use    <= pwdata[WAYS_W-1:0];
        REG_OFFSET_BITS:    offset_bits    <= pwdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SET_INDEX_BITS: prdata = PDATA_W'(set_index_bits);
      REG_WAYS_IN_USE:    prdata = PDATA_W'(ways_in_use);
      REG_OFFSET_BITS:    prdata = PDATA_W'(offset_bits);
      default:            prdata = '0;
    endcase
  end

  // clamp the registers to what the storage supports
  logic [SB_W-1:0]  set_bits_eff;
  logic [CNT_W-1:0] ways_eff;

  always_comb begin
    if (int'(set_index_bits) > MAX_SET_BITS) set_bits_eff = SB_W'(MAX_SET_BITS);
    else set_bits_eff = SB_W'(set_index_bits);
    if (ways_in_use == '0) ways_eff = CNT_W'(1);
    else if (int'(ways_in_use) > MAX_WAYS) ways_eff = CNT_W'(MAX_WAYS);
    else ways_eff = CNT_W'(ways_in_use);
  end

  // front end into the queue
  logic             fr_push;
  logic [ENT_W-1:0] fr_entry;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [ENT_W-1:0] q_head;

  assign req_stall = q_full;

  lrusc_front #(
    .SET_W (SET_W),
    .SB_W  (SB_W),
    .ENT_W (ENT_W)
  ) u_front (
    .req_valid   (req_valid),
    .req         (req),
    .set_bits    (set_bits_eff),
    .offset_bits (offset_bits),
    .push        (fr_push),
    .entry       (fr_entry)
  );

  lrusc_queue #(
    .ENT_W (ENT_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fr_push),
    .push_data (fr_entry),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // back end: lookup, replacement, totals, response register
  lrusc_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .STAMP_BITS   (STAMP_BITS),
    .SET_W        (SET_W),
    .CNT_W        (CNT_W),
    .ENT_W        (ENT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ways      (ways_eff),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // a response is either a hit or a miss
  a_hit_xor_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.was_hit != rsp.was_miss))
    else $error("response is not exactly one of hit and miss");

  // an eviction only happens on a miss
  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.was_eviction) |-> rsp.was_miss)
    else $error("eviction reported on a hit");

  // a modify always leaves a nonzero hit total
  a_modify_hits: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.extra_hit) |-> (rsp.hit_total != '0))
    else $error("modify reported with zero hit total");

  // nothing is popped from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
